FILE: rtl/msqrt_pkg.sv
// Package for the modular square root block.
// Holds the operand width, the non-residue search limit and the word types.
// No dependencies.
package msqrt_pkg;

  localparam int W = 32;
  localparam int NR_LIMIT = 4096;
  localparam int NRW = $clog2(NR_LIMIT);

  typedef struct packed {
    logic signed [W:0] value;
    logic [W-1:0]      modulus;
  } req_t;

  typedef struct packed {
    logic [W-1:0] root;
    logic         status;
  } rsp_t;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_NONE = 1'b1;

endpackage

FILE: rtl/modular_square_root.sv
// Modular square root (Tonelli-Shanks) on one shared modular multiplier.
// Each modular product walks the multiplier bits, doubling and then adding and
// reducing for each bit; an exponentiation runs one or two products per exponent bit.
// The run time of an item is set by the exponentiations and the
// non-residue search (up to 4096 candidates, one exponentiation each). One item at a time.
// Reset (rst, synchronous) returns the sequencer to idle and drops rsp_valid.
// Depends on msqrt_pkg.
module modular_square_root import msqrt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam logic [4:0] S_IDLE = 5'd0, S_RED = 5'd1, S_RED_D = 5'd2, S_EUL = 5'd3,
    S_FIN3 = 5'd4, S_SQ = 5'd5, S_NR_CHK = 5'd6, S_TS_C = 5'd7, S_TS_T = 5'd8,
    S_TS_R = 5'd9, S_LOOP = 5'd10, S_ORD = 5'd11, S_ORD_D = 5'd12, S_BSQ = 5'd13,
    S_BSQ_D = 5'd14, S_UPD_C = 5'd15, S_UPD_T = 5'd16, S_UPD_R = 5'd17,
    S_MUL = 5'd18, S_PW_RED = 5'd19, S_PW_RB = 5'd20, S_PW_LOOP = 5'd21,
    S_PW_MD = 5'd22, S_PW_SQ = 5'd23, S_PW_SD = 5'd24, S_DONE = 5'd25;

  logic [4:0] state, mret, pret;
  logic [W:0] raw;
  logic [W-1:0] p, a, q, c, t, rr, b, sq, half;
  logic [5:0] s, mm, i, kk;
  logic [NRW-1:0] k;
  logic [NRW:0] n;
  logic [W-1:0] pb, pe, pr;
  logic [W-1:0] ma, mr;
  logic [W:0] mb;
  logic [5:0] mcnt;
  logic mph;
  rsp_t res;

  logic [W:0] mul_x, mul_y, mag, av33;
  logic [W-1:0] av;
  logic [6:0] bsq_lhs;

  // Multiplier step: double the partial sum, or add the multiplicand when the top
  // multiplier bit is set, then bring the result back below p with one conditional subtract.
  assign mul_x = mph ? ({1'b0, mr} + (mb[W] ? {1'b0, ma} : '0)) : {mr, 1'b0};
  assign mul_y = (mul_x >= {1'b0, p}) ? mul_x - {1'b0, p} : mul_x;
  assign mag = -raw;
  assign av33 = raw[W] ? ((mr == '0) ? '0 : {1'b0, p} - {1'b0, mr}) : {1'b0, mr};
  assign av = av33[W-1:0];
  assign bsq_lhs = {1'b0, kk} + {1'b0, i} + 7'd1;
  assign half = (p - 1'b1) >> 1;
  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            raw <= req.value;
            p <= req.modulus;
            if (req.modulus < W'(2)) begin
              res <= '{root: '0, status: ST_NONE};
              state <= S_DONE;
            end else begin
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          ma <= W'(1); mb <= raw[W] ? mag : raw; mr <= '0; mcnt <= 6'(W + 1);
          mph <= 1'b0; mret <= S_RED_D; state <= S_MUL;
        end
        S_RED_D: begin
          a <= av;
          if (av == '0) begin
            res <= '{root: '0, status: ST_OK}; state <= S_DONE;
          end else if (p == W'(2)) begin
            res <= '{root: av, status: ST_OK}; state <= S_DONE;
          end else begin
            pb <= av; pe <= half; pr <= W'(1); pret <= S_EUL; state <= S_PW_RED;
          end
        end
        S_EUL: begin
          if (pr == p - 1'b1) begin
            res <= '{root: '0, status: ST_NONE}; state <= S_DONE;
          end else if (p[1:0] == 2'b11) begin
            pb <= a; pe <= W'(({1'b0, p} + 1'b1) >> 2); pr <= W'(1);
            pret <= S_FIN3; state <= S_PW_RED;
          end else begin
            q <= p - 1'b1; s <= '0; state <= S_SQ;
          end
        end
        S_FIN3: begin
          res <= '{root: pr, status: ST_OK}; state <= S_DONE;
        end
        S_SQ: begin
          if (!q[0]) begin
            q <= q >> 1; s <= s + 1'b1;
          end else begin
            n <= (NRW+1)'(2); k <= '0;
            pb <= W'(2); pe <= half; pr <= W'(1); pret <= S_NR_CHK; state <= S_PW_RED;
          end
        end
        S_NR_CHK: begin
          if (pr == p - 1'b1) begin
            pb <= W'(n); pe <= q; pr <= W'(1); pret <= S_TS_C; state <= S_PW_RED;
          end else if (k == NRW'(NR_LIMIT - 1)) begin
            res <= '{root: '0, status: ST_NONE}; state <= S_DONE;
          end else begin
            n <= n + 1'b1; k <= k + 1'b1;
            pb <= W'(n + 1'b1); pe <= half; pr <= W'(1); pret <= S_NR_CHK;
            state <= S_PW_RED;
          end
        end
        S_TS_C: begin
          c <= pr; pb <= a; pe <= q; pr <= W'(1); pret <= S_TS_T; state <= S_PW_RED;
        end
        S_TS_T: begin
          t <= pr; pb <= a; pe <= W'(({1'b0, q} + 1'b1) >> 1); pr <= W'(1);
          pret <= S_TS_R; state <= S_PW_RED;
        end
        S_TS_R: begin
          rr <= pr; mm <= s; state <= S_LOOP;
        end
        S_LOOP: begin
          if (t == W'(1)) begin
            res <= '{root: rr, status: ST_OK}; state <= S_DONE;
          end else if (t == '0) begin
            res <= '{root: '0, status: ST_OK}; state <= S_DONE;
          end else begin
            i <= '0; sq <= t; state <= S_ORD;
          end
        end
        S_ORD: begin
          if (sq != W'(1) && i < mm) begin
            ma <= sq; mb <= {1'b0, sq}; mr <= '0; mcnt <= 6'(W + 1); mph <= 1'b0;
            mret <= S_ORD_D; state <= S_MUL;
          end else if (sq != W'(1) || i >= mm) begin
            res <= '{root: '0, status: ST_NONE}; state <= S_DONE;
          end else begin
            b <= c; kk <= '0; state <= S_BSQ;
          end
        end
        S_ORD_D: begin
          sq <= mr; i <= i + 1'b1; state <= S_ORD;
        end
        S_BSQ: begin
          ma <= b; mb <= {1'b0, b}; mr <= '0; mcnt <= 6'(W + 1); mph <= 1'b0;
          state <= S_MUL;
          if (bsq_lhs < {1'b0, mm}) begin
            mret <= S_BSQ_D;
          end else begin
            mm <= i; mret <= S_UPD_C;
          end
        end
        S_BSQ_D: begin
          b <= mr; kk <= kk + 1'b1; state <= S_BSQ;
        end
        S_UPD_C: begin
          c <= mr; ma <= t; mb <= {1'b0, mr}; mr <= '0; mcnt <= 6'(W + 1);
          mph <= 1'b0; mret <= S_UPD_T; state <= S_MUL;
        end
        S_UPD_T: begin
          t <= mr; ma <= rr; mb <= {1'b0, b}; mr <= '0; mcnt <= 6'(W + 1);
          mph <= 1'b0; mret <= S_UPD_R; state <= S_MUL;
        end
        S_UPD_R: begin
          rr <= mr; state <= S_LOOP;
        end
        S_MUL: begin
          mr <= mul_y[W-1:0];
          mph <= ~mph;
          if (mph) begin
            mb <= mb << 1;
            mcnt <= mcnt - 1'b1;
            if (mcnt == 6'd1) state <= mret;
          end
        end
        // Exponentiation: reduce the base first, then right-to-left
        // square-and-multiply over the exponent bits.
        S_PW_RED: begin
          ma <= W'(1); mb <= {1'b0, pb}; mr <= '0; mcnt <= 6'(W + 1); mph <= 1'b0;
          mret <= S_PW_RB; state <= S_MUL;
        end
        S_PW_RB: begin
          pb <= mr; state <= S_PW_LOOP;
        end
        S_PW_LOOP: begin
          if (pe == '0) begin
            state <= pret;
          end else if (pe[0]) begin
            ma <= pr; mb <= {1'b0, pb}; mr <= '0; mcnt <= 6'(W + 1); mph <= 1'b0;
            mret <= S_PW_MD; state <= S_MUL;
          end else begin
            state <= S_PW_SQ;
          end
        end
        S_PW_MD: begin
          pr <= mr; state <= S_PW_SQ;
        end
        S_PW_SQ: begin
          ma <= pb; mb <= {1'b0, pb}; mr <= '0; mcnt <= 6'(W + 1); mph <= 1'b0;
          mret <= S_PW_SD; state <= S_MUL;
        end
        S_PW_SD: begin
          pb <= mr; pe <= pe >> 1; state <= S_PW_LOOP;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp <= res; rsp_valid <= 1'b1; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> state != S_IDLE)
    else $error("accepted word left the sequencer idle");

  a_mcnt_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> (mcnt != '0 && mcnt <= 6'(W + 1)))
    else $error("multiplier bit count out of range");

  a_partial_reduced: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> mr < p)
    else $error("multiplier partial sum not reduced");

  a_none_zero_root: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_NONE) |-> rsp.root == '0)
    else $error("no-root word carries a nonzero root");

endmodule
